// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Default heap geometry
   localparam int DEF_BLOCK_COUNT = 64;
   localparam int DEF_BLOCK_BYTES = 64;

   // Fixed field widths
   localparam int ADDR_W  = 32;
   localparam int FREED_W = 13;

   // Request kinds
   localparam logic FUNC_RESERVE = 1'b0;
   localparam logic FUNC_FREE    = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Per-block marks held in the mark memory
   typedef struct packed {
      logic used;
      logic chain_end;
   } mark_type;

endpackage

// ===== design/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit contiguous allocator over a heap of fixed-size blocks. The used
// and chain-end marks of every block live in one synchronous memory that is
// walked one block per cycle.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------------
//   request  | start / busy              | req_func, req_size_bytes, req_address
//   response | rsp_valid (1-cycle pulse) | rsp_status, rsp_granted_address, rsp_freed_bytes
//   csr      | csr_valid / csr_ready     | csr_wdata (heap base address)
//
// Reset clears the marks in a pass over every block; busy is high during
// it. A reserve that fails its size check, or a free outside the heap, answers
// the cycle after accept. Otherwise a reserve scans k blocks through the memory
// read port (up to BLOCK_COUNT), then marks n blocks through the write port. A
// free does b block-bound compares to find the block, then clears m blocks up
// to the chain end or the heap end. The response cannot be stalled; busy drops
// with the response strobe.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_size_bytes,
   input  logic [ADDR_W-1:0]  req_address,
   // response channel
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [ADDR_W-1:0]  rsp_granted_address,
   output logic [FREED_W-1:0] rsp_freed_bytes,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ADDR_W-1:0]  csr_wdata
);

   // Geometry
   localparam int                IDX_W      = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam longint            HEAP_BYTES = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);
   localparam int                HEAP_W     = $clog2(HEAP_BYTES + 1);
   localparam logic [ADDR_W-1:0] HEAP_LIM   = ADDR_W'(HEAP_BYTES);
   localparam logic [HEAP_W-1:0] BB_H       = HEAP_W'(BLOCK_BYTES);
   localparam logic [FREED_W-1:0] BB_F      = FREED_W'(BLOCK_BYTES % (2 ** FREED_W));
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(BLOCK_COUNT - 1);

   // State codes
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_R_SCAN = 3'd2;
   localparam logic [2:0] ST_R_MARK = 3'd3;
   localparam logic [2:0] ST_F_FIND = 3'd4;
   localparam logic [2:0] ST_F_WALK = 3'd5;

   // Control registers
   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   ev_idx_ff, ev_idx_in;     // block under work / clear counter
   logic [HEAP_W-1:0]  acc_ff, acc_in;           // run bytes (scan) or block bound (find)
   logic               first_ff, first_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  heap_base_ff;

   // Working registers
   logic [HEAP_W-1:0]  ev_off_ff, ev_off_in;     // byte offset of ev_idx
   logic [IDX_W-1:0]   start_idx_ff, start_idx_in;
   logic [HEAP_W-1:0]  start_off_ff, start_off_in;
   logic [IDX_W-1:0]   end_idx_ff, end_idx_in;
   logic [HEAP_W-1:0]  size_ff, size_in;
   logic [HEAP_W-1:0]  offset_ff, offset_in;
   logic [FREED_W-1:0] freed_ff, freed_in;

   // Response payload
   logic               rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_granted_ff, rsp_granted_in;
   logic [FREED_W-1:0] rsp_freed_ff, rsp_freed_in;

   // Mark memory
   mark_type           mark_mem [BLOCK_COUNT];
   mark_type           rd_data_ff;
   logic               mem_we;
   mark_type           mem_wdata;

   logic [HEAP_W:0]    run_sum;
   logic [ADDR_W:0]    addr_diff;
   logic               run_found;

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_freed_bytes     = rsp_freed_ff;

   assign run_sum   = {1'b0, acc_ff} + {1'b0, BB_H};
   assign addr_diff = {1'b0, req_address} - {1'b0, heap_base_ff};
   assign run_found = rd_data_ff.used == 1'b0 && run_sum >= {1'b0, size_ff};

   // Mark memory: one write port, one read port with registered data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[ev_idx_ff] <= mem_wdata;
      end
      rd_data_ff <= mark_mem[ev_idx_in];
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      ev_idx_in      = ev_idx_ff;
      ev_off_in      = ev_off_ff;
      acc_in         = acc_ff;
      first_in       = first_ff;
      start_idx_in   = start_idx_ff;
      start_off_in   = start_off_ff;
      end_idx_in     = end_idx_ff;
      size_in        = size_ff;
      offset_in      = offset_ff;
      freed_in       = freed_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_freed_in   = rsp_freed_ff;
      mem_we         = 1'b0;
      mem_wdata      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ev_idx_ff == LAST_IDX) begin
               ev_idx_in = '0;
               state_in  = ST_IDLE;
            end else begin
               ev_idx_in = ev_idx_ff + IDX_W'(1);
            end
         end

         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_RESERVE) begin
                  if (req_size_bytes == '0 || req_size_bytes > HEAP_LIM) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_FAIL;
                     rsp_granted_in = '0;
                     rsp_freed_in   = '0;
                  end else begin
                     size_in   = req_size_bytes[HEAP_W-1:0];
                     acc_in    = '0;
                     ev_idx_in = '0;
                     ev_off_in = '0;
                     state_in  = ST_R_SCAN;
                  end
               end else begin
                  // below base, or at/after heap end: out of range
                  if (addr_diff[ADDR_W] || addr_diff[ADDR_W-1:0] >= HEAP_LIM) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = STATUS_FAIL;
                     rsp_granted_in = '0;
                     rsp_freed_in   = '0;
                  end else begin
                     offset_in = addr_diff[HEAP_W-1:0];
                     ev_idx_in = '0;
                     acc_in    = BB_H;
                     state_in  = ST_F_FIND;
                  end
               end
            end
         end

         // one block's marks arrive per cycle; track the current free run
         ST_R_SCAN: begin
            if (rd_data_ff.used) begin
               acc_in = '0;
            end else begin
               if (acc_ff == '0) begin
                  start_idx_in = ev_idx_ff;
                  start_off_in = ev_off_ff;
               end
               acc_in = run_sum[HEAP_W-1:0];
            end
            if (run_found) begin
               end_idx_in = ev_idx_ff;
               ev_idx_in  = start_idx_in;
               state_in   = ST_R_MARK;
            end else if (ev_idx_ff == LAST_IDX) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_FAIL;
               rsp_granted_in = '0;
               rsp_freed_in   = '0;
               state_in       = ST_IDLE;
            end else begin
               ev_idx_in = ev_idx_ff + IDX_W'(1);
               ev_off_in = ev_off_ff + BB_H;
            end
         end

         // write used marks over the run, chain end on its last block
         ST_R_MARK: begin
            mem_we              = 1'b1;
            mem_wdata.used      = 1'b1;
            mem_wdata.chain_end = (ev_idx_ff == end_idx_ff);
            if (ev_idx_ff == end_idx_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_granted_in = heap_base_ff + ADDR_W'(start_off_ff);
               rsp_freed_in   = '0;
               state_in       = ST_IDLE;
            end else begin
               ev_idx_in = ev_idx_ff + IDX_W'(1);
            end
         end

         // locate the block holding the offset by walking block bounds
         ST_F_FIND: begin
            if (offset_ff < acc_ff) begin
               first_in = 1'b1;
               freed_in = '0;
               state_in = ST_F_WALK;
            end else begin
               ev_idx_in = ev_idx_ff + IDX_W'(1);
               acc_in    = acc_ff + BB_H;
            end
         end

         // clear blocks up to the chain end or the heap end
         ST_F_WALK: begin
            first_in = 1'b0;
            if (first_ff && !rd_data_ff.used) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_FAIL;
               rsp_granted_in = '0;
               rsp_freed_in   = '0;
               state_in       = ST_IDLE;
            end else begin
               mem_we   = 1'b1;
               freed_in = freed_ff + BB_F;
               if (rd_data_ff.chain_end || ev_idx_ff == LAST_IDX) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = STATUS_OK;
                  rsp_granted_in = '0;
                  rsp_freed_in   = freed_in;
                  state_in       = ST_IDLE;
               end else begin
                  ev_idx_in = ev_idx_ff + IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ev_idx_ff    <= '0;
         acc_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ev_idx_ff    <= ev_idx_in;
         acc_ff       <= acc_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            heap_base_ff <= csr_wdata;
         end
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      ev_off_ff      <= ev_off_in;
      start_idx_ff   <= start_idx_in;
      start_off_ff   <= start_off_in;
      end_idx_ff     <= end_idx_in;
      size_ff        <= size_in;
      offset_ff      <= offset_in;
      freed_ff       <= freed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   // Assertions
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

   a_fail_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FAIL) |->
         (rsp_granted_address == '0 && rsp_freed_bytes == '0))
      else $error("failed response with nonzero payload");

   a_scan_run_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_SCAN) |-> (acc_ff < size_ff))
      else $error("scan continued past a long enough run");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_MARK) |->
         (ev_idx_ff >= start_idx_ff && ev_idx_ff <= end_idx_ff))
      else $error("mark write outside the found run");

endmodule

// ===== tb/sv/ffba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Watches the request, response and csr channels of the first-fit block
// allocator. It keeps its own copy of the heap base and the per-block used
// and chain-end marks, works out the reply of every accepted item, and
// compares each response strobe field by field with the oldest reply still
// waiting.
// ----------------------------------------------------------------------------
module ffba_checker
   import ffba_pkg::*;
#(
   parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
   parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_func,
   input  logic [ADDR_W-1:0]  req_size_bytes,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic               rsp_valid,
   input  logic               rsp_status,
   input  logic [ADDR_W-1:0]  rsp_granted_address,
   input  logic [FREED_W-1:0] rsp_freed_bytes,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [ADDR_W-1:0]  csr_wdata,
   output int                 error_count,
   output int                 pending_count
);

   localparam longint HEAP_BYTES = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);

   typedef struct packed {
      logic               status;
      logic [ADDR_W-1:0]  granted;
      logic [FREED_W-1:0] freed;
   } reply_type;

   // allocator state as predicted
   logic [ADDR_W-1:0] heap_base;
   logic              used_mark [BLOCK_COUNT];
   logic              end_mark  [BLOCK_COUNT];
   reply_type         expected_replies [$];
   int                errors  = 0;
   int                waiting = 0;

   assign error_count   = errors;
   assign pending_count = waiting;

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors = errors + 1;
   endtask

   // first run of free blocks long enough for the rounded-up size
   function automatic reply_type reserve_chain(input logic [ADDR_W-1:0] size);
      reply_type r;
      longint sz;
      longint need;
      int     run_start;
      int     run;
      int     b;
      bit     found;
      r         = '{status: STATUS_FAIL, granted: '0, freed: '0};
      sz        = size;
      run_start = 0;
      run       = 0;
      found     = 1'b0;
      if (sz == 0 || sz > HEAP_BYTES) return r;
      need = (sz + BLOCK_BYTES - 1) / BLOCK_BYTES;
      for (b = 0; b < BLOCK_COUNT; b++) begin
         if (used_mark[b]) begin
            run = 0;
         end else begin
            if (run == 0) run_start = b;
            run++;
            if (run >= need) begin
               found = 1'b1;
               break;
            end
         end
      end
      if (!found) return r;
      for (b = run_start; b < run_start + run; b++) begin
         used_mark[b] = 1'b1;
         end_mark[b]  = 1'b0;
      end
      end_mark[run_start + run - 1] = 1'b1;
      r.status  = STATUS_OK;
      r.granted = heap_base + ADDR_W'(run_start * BLOCK_BYTES);
      return r;
   endfunction

   // release from the addressed block up to the chain end or the heap end
   function automatic reply_type release_chain(input logic [ADDR_W-1:0] addr);
      reply_type r;
      longint a;
      longint base;
      longint offs;
      longint cnt;
      int     b;
      bit     last;
      r    = '{status: STATUS_FAIL, granted: '0, freed: '0};
      a    = addr;
      base = heap_base;
      if (a < base) return r;
      offs = a - base;
      if (offs >= HEAP_BYTES) return r;
      b = int'(offs / BLOCK_BYTES);
      if (!used_mark[b]) return r;
      cnt = 0;
      while (b < BLOCK_COUNT) begin
         last         = end_mark[b];
         used_mark[b] = 1'b0;
         end_mark[b]  = 1'b0;
         cnt++;
         b++;
         if (last) break;
      end
      r.status = STATUS_OK;
      r.freed  = FREED_W'(cnt * BLOCK_BYTES);
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      int        pushed;
      int        popped;
      pushed = 0;
      popped = 0;
      if (reset) begin
         heap_base = '0;
         for (int b = 0; b < BLOCK_COUNT; b++) begin
            used_mark[b] = 1'b0;
            end_mark[b]  = 1'b0;
         end
         expected_replies.delete();
         waiting <= 0;
      end else begin
         // csr write
         if (csr_valid && csr_ready) heap_base = csr_wdata;

         // response strobe belongs to the oldest item
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               report_error("response strobe with no item outstanding");
            end else begin
               want   = expected_replies.pop_front();
               popped = 1;
               if (rsp_status !== want.status)
                  report_error($sformatf("status: got %0b expected %0b",
                                         rsp_status, want.status));
               if (rsp_granted_address !== want.granted)
                  report_error($sformatf("granted_address: got 0x%08h expected 0x%08h",
                                         rsp_granted_address, want.granted));
               if (rsp_freed_bytes !== want.freed)
                  report_error($sformatf("freed_bytes: got %0d expected %0d",
                                         rsp_freed_bytes, want.freed));
            end
         end

         // accepted item
         if (start && !busy) begin
            if (req_func == FUNC_RESERVE) want = reserve_chain(req_size_bytes);
            else                          want = release_chain(req_address);
            expected_replies.push_back(want);
            pushed = 1;
         end
         waiting <= waiting + pushed - popped;
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the first-fit block allocator: a directed pass over the size
// and address corner cases, then random reserve/free traffic under three
// sender idle rates and several heap base settings. Checking is done by
// ffba_checker; this module only drives items and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   import ffba_pkg::*;

   localparam int HEAP_BYTES = DEF_BLOCK_COUNT * DEF_BLOCK_BYTES;

   logic               clock;
   logic               reset;
   logic               start;
   logic               req_func;
   logic [ADDR_W-1:0]  req_size_bytes;
   logic [ADDR_W-1:0]  req_address;
   logic               csr_valid;
   logic [ADDR_W-1:0]  csr_wdata;
   logic               busy;
   logic               rsp_valid;
   logic               rsp_status;
   logic [ADDR_W-1:0]  rsp_granted_address;
   logic [FREED_W-1:0] rsp_freed_bytes;
   logic               csr_ready;
   int                 error_count;
   int                 pending_count;

   // stimulus-side view of the base, used to aim frees into the heap
   logic [ADDR_W-1:0]  base_addr;
   int                 idle_pct;

   first_fit_block_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_size_bytes      (req_size_bytes),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_freed_bytes     (rsp_freed_bytes),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   ffba_checker check_i (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_size_bytes      (req_size_bytes),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_freed_bytes     (rsp_freed_bytes),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata),
      .error_count         (error_count),
      .pending_count       (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      #3000000;
      $display("tb failed");
      $finish;
   end

   // one item; start stays high afterwards until the next call or a drain
   task automatic send_item(input logic f, input logic [ADDR_W-1:0] sz,
                            input logic [ADDR_W-1:0] ad);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_func       <= f;
      req_size_bytes <= sz;
      req_address    <= ad;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off until every outstanding item has answered and the block is idle
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
   endtask

   task automatic write_base(input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      base_addr = value;
   endtask

   // random reserve/free mix, mostly small chains and frees inside the heap
   task automatic random_item;
      int                pick;
      logic [ADDR_W-1:0] sz;
      logic [ADDR_W-1:0] ad;
      pick = $urandom_range(99);
      sz   = $urandom;
      ad   = $urandom;
      if (pick < 50) begin
         case ($urandom_range(9))
            0: sz = $urandom_range(1, HEAP_BYTES);
            1: begin
               case ($urandom_range(2))
                  0: sz = '0;
                  1: sz = HEAP_BYTES;
                  default: sz = HEAP_BYTES + 1;
               endcase
            end
            2: ;
            default: sz = $urandom_range(1, 8 * DEF_BLOCK_BYTES);
         endcase
         send_item(FUNC_RESERVE, sz, ad);
      end else begin
         if (pick < 92) begin
            ad = base_addr + $urandom_range(HEAP_BYTES - 1);
         end else if (pick < 96) begin
            case ($urandom_range(2))
               0: ad = base_addr - 1;
               1: ad = base_addr + HEAP_BYTES;
               default: ad = base_addr + HEAP_BYTES - 1;
            endcase
         end
         send_item(FUNC_FREE, sz, ad);
      end
   endtask

   task automatic run_phase(input int pct, input int n, input logic [ADDR_W-1:0] base);
      write_base(base);
      idle_pct = pct;
      for (int i = 0; i < n; i++) begin
         random_item();
         // sender pauses mid-phase until the pipeline is empty
         if (i == n / 2) drain();
      end
      drain();
   endtask

   initial begin
      start          <= 1'b0;
      req_func       <= FUNC_RESERVE;
      req_size_bytes <= '0;
      req_address    <= '0;
      csr_valid      <= 1'b0;
      csr_wdata      <= '0;
      base_addr      = '0;
      idle_pct       = 0;
      reset          <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      drain();
      write_base(32'h0000_0000);

      // size checks, whole heap, no room, mid-chain free, missing chain end
      send_item(FUNC_RESERVE, 32'h0000_0000, $urandom);
      send_item(FUNC_RESERVE, HEAP_BYTES + 1, $urandom);
      send_item(FUNC_RESERVE, 32'hFFFF_FFFF, $urandom);
      send_item(FUNC_RESERVE, HEAP_BYTES, $urandom);
      send_item(FUNC_RESERVE, 32'd1, $urandom);
      send_item(FUNC_FREE, $urandom, 32'd100);
      send_item(FUNC_FREE, $urandom, 32'd0);
      send_item(FUNC_FREE, $urandom, 32'd0);
      send_item(FUNC_FREE, $urandom, HEAP_BYTES);
      send_item(FUNC_FREE, $urandom, 32'hFFFF_FFFF);
      // first fit around a hole
      send_item(FUNC_RESERVE, 32'd1, $urandom);
      send_item(FUNC_RESERVE, DEF_BLOCK_BYTES, $urandom);
      send_item(FUNC_RESERVE, DEF_BLOCK_BYTES + 1, $urandom);
      send_item(FUNC_FREE, $urandom, 2 * DEF_BLOCK_BYTES - 1);
      send_item(FUNC_RESERVE, 2 * DEF_BLOCK_BYTES, $urandom);
      send_item(FUNC_RESERVE, DEF_BLOCK_BYTES, $urandom);
      drain();

      // base at the top: granted address wraps, heap past 2^32 is unreachable
      write_base(32'hFFFF_FFFF);
      send_item(FUNC_FREE, $urandom, 32'hFFFF_FFFF);
      send_item(FUNC_FREE, $urandom, 32'hFFFF_FFFE);
      send_item(FUNC_RESERVE, DEF_BLOCK_BYTES, $urandom);
      send_item(FUNC_RESERVE, 2 * DEF_BLOCK_BYTES, $urandom);
      drain();

      // heap bounds around a mid-range base
      write_base(32'h1000_0000);
      send_item(FUNC_FREE, $urandom, 32'h0FFF_FFFF);
      send_item(FUNC_FREE, $urandom, 32'h1000_0000 + HEAP_BYTES - 1);
      send_item(FUNC_FREE, $urandom, 32'h1000_0000 + HEAP_BYTES);
      send_item(FUNC_FREE, $urandom, 32'h1000_0000);
      drain();

      // random traffic under three sender idle rates
      run_phase(6, 320, $urandom);
      run_phase(68, 320, 32'hFFFF_F800);
      run_phase(0, 320, 32'h0000_0000);

      drain();
      repeat (150) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ffba_pkg.sv
design/first_fit_block_allocator.sv
tb/sv/ffba_checker.sv
tb/sv/tb.sv
